### rtl/tof_result_status_and_spad_control_unit_macros.svh
// Assertion macros shared by the time-of-flight result unit.
// Depends on nothing; included by files that assert.
`ifndef TOF_RESULT_STATUS_AND_SPAD_CONTROL_UNIT_MACROS_SVH
`define TOF_RESULT_STATUS_AND_SPAD_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TOF_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("tof unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TOF_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("tof unit: next-cycle check failed");

`endif

### rtl/tof_rs_pkg.sv
// Package for the time-of-flight result unit: types, constants, status decode.
// Depends on nothing.
`default_nettype none
package tof_rs_pkg;

   localparam int DIV_W  = 32;
   localparam int DIV_IW = $clog2(DIV_W);
   localparam int LAST   = 2 * DIV_W;

   localparam logic [15:0] TARGET_RATE_RST = 16'd2560;
   localparam logic [10:0] RANGE_SCALE     = 11'd2011;
   localparam logic [26:0] RANGE_ROUND     = 27'h400;
   localparam int          RANGE_SHIFT     = 11;
   localparam logic [15:0] SPAD_DEFAULT    = 16'h8000;
   localparam logic [15:0] SAT16           = 16'hFFFF;

   localparam logic [3:0] ST_VALID    = 4'd0;
   localparam logic [3:0] ST_SIGMA    = 4'd1;
   localparam logic [3:0] ST_SIGNAL   = 4'd2;
   localparam logic [3:0] ST_CLIPPED  = 4'd3;
   localparam logic [3:0] ST_BOUNDS   = 4'd4;
   localparam logic [3:0] ST_HW       = 4'd5;
   localparam logic [3:0] ST_NOWRAP   = 4'd6;
   localparam logic [3:0] ST_WRAP     = 4'd7;
   localparam logic [3:0] ST_XTALK    = 4'd8;
   localparam logic [3:0] ST_SYNC     = 4'd9;
   localparam logic [3:0] ST_MINRANGE = 4'd10;
   localparam logic [3:0] ST_NONE     = 4'd11;

   typedef struct packed {
      logic              valid;
      logic              dflt;
      logic [7:0]        raw_status;
      logic [7:0]        stream_cnt;
      logic [15:0]       ambient_rate;
      logic [15:0]       signal_rate;
      logic [15:0]       raw_range;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
      logic [DIV_W-1:0]  rem;
      logic [DIV_W-1:0]  quo;
   } pipe_type;

   function automatic logic [3:0] decode_status(input logic [7:0] raw,
                                                input logic [7:0] stream);
      logic [3:0] code;
      case (raw)
         8'd1, 8'd2, 8'd3, 8'd17: code = ST_HW;
         8'd4:  code = ST_SIGNAL;
         8'd5:  code = ST_BOUNDS;
         8'd6:  code = ST_SIGMA;
         8'd7:  code = ST_WRAP;
         8'd8:  code = ST_CLIPPED;
         8'd9:  code = (stream == 8'd0) ? ST_NOWRAP : ST_VALID;
         8'd12: code = ST_XTALK;
         8'd13: code = ST_MINRANGE;
         8'd18: code = ST_SYNC;
         default: code = ST_NONE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

### rtl/tof_result_status_and_spad_control_unit.sv
// A start transfer passes pipe_ff[0] through pipe_ff[LAST], then the output register, to the rsp_valid strobe.
// Throughput: one record per cycle; busy stays low, the pipeline never stalls.
// Built from two 32-stage restoring dividers, one quotient bit per stage.
// Reset (synchronous, active high) clears all valid bits and loads
// target_rate with 2560; payload registers are not reset.
// Depends on tof_rs_pkg and the assertion macro header.
`default_nettype none
`include "tof_result_status_and_spad_control_unit_macros.svh"
module tof_result_status_and_spad_control_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_raw_status,
   input  wire logic [7:0]  req_stream_cnt,
   input  wire logic [15:0] req_effective_spads,
   input  wire logic [15:0] req_ambient_rate,
   input  wire logic [15:0] req_signal_rate,
   input  wire logic [15:0] req_raw_range,
   output logic             rsp_valid,
   output logic [15:0]      rsp_distance,
   output logic [3:0]       rsp_status_code,
   output logic [15:0]      rsp_spad_select,
   output logic [15:0]      rsp_signal_rate_out,
   output logic [15:0]      rsp_ambient_rate_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_target_rate
);

   // Configuration register: target total rate, 9.7 fixed point.
   logic [15:0] target_rate_ff;

   // Pipeline: stage 0 captures the record, stages 1..DIV_W divide the
   // saturated total rate by the SPAD count, the rest divide the target by
   // the per-SPAD rate.
   tof_rs_pkg::pipe_type pipe_ff [0:tof_rs_pkg::LAST];
   tof_rs_pkg::pipe_type pipe_in [0:tof_rs_pkg::LAST];

   logic [16:0] total_sum;
   logic [15:0] total_sat;

   logic        rsp_valid_ff;
   logic [15:0] rsp_distance_ff, rsp_distance_in;
   logic [3:0]  rsp_status_code_ff, rsp_status_code_in;
   logic [15:0] rsp_spad_select_ff, rsp_spad_select_in;
   logic [15:0] rsp_signal_ff, rsp_ambient_ff;
   logic [26:0] range_prod;

   // Never stall: every stage advances each cycle.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_rate_ff <= tof_rs_pkg::TARGET_RATE_RST;
      end else if (csr_valid && csr_ready) begin
         target_rate_ff <= csr_target_rate;
      end
   end

   // Saturate signal plus ambient to 16 bits before it enters the divider.
   assign total_sum = {1'b0, req_signal_rate} + {1'b0, req_ambient_rate};
   assign total_sat = total_sum[16] ? tof_rs_pkg::SAT16 : total_sum[15:0];

   always_comb begin
      tof_rs_pkg::pipe_type          src;
      logic [tof_rs_pkg::DIV_W:0]    trial;
      logic [tof_rs_pkg::DIV_IW-1:0] bidx;
      logic                          qbit;

      pipe_in[0].valid        = start && !busy && !reset;
      pipe_in[0].dflt         = (req_effective_spads == 16'd0);
      pipe_in[0].raw_status   = req_raw_status;
      pipe_in[0].stream_cnt   = req_stream_cnt;
      pipe_in[0].ambient_rate = req_ambient_rate;
      pipe_in[0].signal_rate  = req_signal_rate;
      pipe_in[0].raw_range    = req_raw_range;
      pipe_in[0].dividend     = {total_sat, 16'd0};
      pipe_in[0].divisor      = {16'd0, req_effective_spads};
      pipe_in[0].rem          = '0;
      pipe_in[0].quo          = '0;

      for (int k = 1; k <= tof_rs_pkg::LAST; k++) begin
         src = pipe_ff[k-1];
         // Hand the per-SPAD rate over to the second divider.
         if (k == tof_rs_pkg::DIV_W + 1) begin
            src.dflt     = src.dflt || (src.quo == '0);
            src.divisor  = src.quo;
            src.dividend = {target_rate_ff, 16'd0};
            src.rem      = '0;
            src.quo      = '0;
         end
         bidx  = tof_rs_pkg::DIV_IW'(tof_rs_pkg::LAST - k);
         trial = {src.rem, src.dividend[bidx]};
         qbit  = (trial >= {1'b0, src.divisor});
         if (qbit) begin
            trial = trial - {1'b0, src.divisor};
         end
         pipe_in[k]       = src;
         pipe_in[k].valid = src.valid && !reset;
         pipe_in[k].rem   = trial[tof_rs_pkg::DIV_W-1:0];
         pipe_in[k].quo   = {src.quo[tof_rs_pkg::DIV_W-2:0], qbit};
      end
   end

   // Advance every stage each cycle; only valid bits see reset.
   always_ff @(posedge clock) begin
      for (int k = 0; k <= tof_rs_pkg::LAST; k++) begin
         pipe_ff[k] <= pipe_in[k];
      end
   end

   // Output stage: scale range, decode status, saturate the SPAD count.
   assign range_prod = 27'(pipe_ff[tof_rs_pkg::LAST].raw_range) * 27'(tof_rs_pkg::RANGE_SCALE)
                       + tof_rs_pkg::RANGE_ROUND;

   always_comb begin
      tof_rs_pkg::pipe_type fin;
      fin                = pipe_ff[tof_rs_pkg::LAST];
      rsp_distance_in    = range_prod[tof_rs_pkg::RANGE_SHIFT +: 16];
      rsp_status_code_in = tof_rs_pkg::decode_status(fin.raw_status, fin.stream_cnt);
      if (fin.dflt) begin
         rsp_spad_select_in = tof_rs_pkg::SPAD_DEFAULT;
      end else if (|fin.quo[tof_rs_pkg::DIV_W-1:16]) begin
         rsp_spad_select_in = tof_rs_pkg::SAT16;
      end else begin
         rsp_spad_select_in = fin.quo[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_ff[tof_rs_pkg::LAST].valid;
      end
      rsp_distance_ff    <= rsp_distance_in;
      rsp_status_code_ff <= rsp_status_code_in;
      rsp_spad_select_ff <= rsp_spad_select_in;
      rsp_signal_ff      <= pipe_ff[tof_rs_pkg::LAST].signal_rate;
      rsp_ambient_ff     <= pipe_ff[tof_rs_pkg::LAST].ambient_rate;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_distance         = rsp_distance_ff;
   assign rsp_status_code      = rsp_status_code_ff;
   assign rsp_spad_select      = rsp_spad_select_ff;
   assign rsp_signal_rate_out  = rsp_signal_ff;
   assign rsp_ambient_rate_out = rsp_ambient_ff;

   // A valid last stage yields a strobe in the next cycle.
   `TOF_ASSERT_NEXT(a_last_to_rsp, clock, reset, pipe_ff[tof_rs_pkg::LAST].valid, rsp_valid)
   // A default-flagged record comes out with the default SPAD count.
   `TOF_ASSERT_NEXT(a_dflt_out, clock, reset, pipe_ff[tof_rs_pkg::LAST].valid && pipe_ff[tof_rs_pkg::LAST].dflt, rsp_spad_select == tof_rs_pkg::SPAD_DEFAULT)
   // Status codes stay within the dense range.
   `TOF_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_status_code <= tof_rs_pkg::ST_NONE)

endmodule
`default_nettype wire

### verif/tof_result_status_and_spad_control_unit_checker.sv
// Checker for the time-of-flight result unit: watches the start, result and
// register channels, predicts each decoded record and compares it.
// Depends on tof_rs_pkg.
module tof_result_status_and_spad_control_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_raw_status,
   input  logic [7:0]  req_stream_cnt,
   input  logic [15:0] req_effective_spads,
   input  logic [15:0] req_ambient_rate,
   input  logic [15:0] req_signal_rate,
   input  logic [15:0] req_raw_range,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_distance,
   input  logic [3:0]  rsp_status_code,
   input  logic [15:0] rsp_spad_select,
   input  logic [15:0] rsp_signal_rate_out,
   input  logic [15:0] rsp_ambient_rate_out,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_target_rate,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] RAW_HW_A     = 8'd1;
   localparam logic [7:0] RAW_HW_B     = 8'd2;
   localparam logic [7:0] RAW_HW_C     = 8'd3;
   localparam logic [7:0] RAW_SIGNAL   = 8'd4;
   localparam logic [7:0] RAW_BOUNDS   = 8'd5;
   localparam logic [7:0] RAW_SIGMA    = 8'd6;
   localparam logic [7:0] RAW_WRAP     = 8'd7;
   localparam logic [7:0] RAW_CLIPPED  = 8'd8;
   localparam logic [7:0] RAW_RANGE_OK = 8'd9;
   localparam logic [7:0] RAW_XTALK    = 8'd12;
   localparam logic [7:0] RAW_MINRANGE = 8'd13;
   localparam logic [7:0] RAW_HW_D     = 8'd17;
   localparam logic [7:0] RAW_SYNC     = 8'd18;

   typedef struct packed {
      logic [15:0] distance;
      logic [3:0]  status_code;
      logic [15:0] spad_select;
      logic [15:0] signal_rate;
      logic [15:0] ambient_rate;
   } record_type;

   record_type  decoded_q[$];
   logic [15:0] target_rate;

   function automatic logic [3:0] status_of(logic [7:0] raw, logic [7:0] stream);
      case (raw)
         RAW_HW_A, RAW_HW_B, RAW_HW_C, RAW_HW_D: return tof_rs_pkg::ST_HW;
         RAW_SIGNAL:   return tof_rs_pkg::ST_SIGNAL;
         RAW_BOUNDS:   return tof_rs_pkg::ST_BOUNDS;
         RAW_SIGMA:    return tof_rs_pkg::ST_SIGMA;
         RAW_WRAP:     return tof_rs_pkg::ST_WRAP;
         RAW_CLIPPED:  return tof_rs_pkg::ST_CLIPPED;
         RAW_RANGE_OK: return (stream == 8'd0) ? tof_rs_pkg::ST_NOWRAP
                                               : tof_rs_pkg::ST_VALID;
         RAW_XTALK:    return tof_rs_pkg::ST_XTALK;
         RAW_MINRANGE: return tof_rs_pkg::ST_MINRANGE;
         RAW_SYNC:     return tof_rs_pkg::ST_SYNC;
         default:      return tof_rs_pkg::ST_NONE;
      endcase
   endfunction

   function automatic logic [15:0] spads_needed(logic [15:0] spads, logic [15:0] sig,
                                                logic [15:0] amb, logic [15:0] target);
      logic [16:0] total;
      logic [31:0] per_spad;
      logic [31:0] need;
      if (spads == 16'd0) return tof_rs_pkg::SPAD_DEFAULT;
      total = {1'b0, sig} + {1'b0, amb};
      if (total > 17'hFFFF) total = 17'hFFFF;
      per_spad = {total[15:0], 16'h0} / {16'h0, spads};
      if (per_spad == 32'd0) return tof_rs_pkg::SPAD_DEFAULT;
      need = {target, 16'h0} / per_spad;
      return (need > 32'hFFFF) ? tof_rs_pkg::SAT16 : need[15:0];
   endfunction

   assign pending = decoded_q.size();

   always @(posedge clock) begin
      record_type want;
      record_type got;
      logic [26:0] scaled;
      if (reset) begin
         target_rate <= tof_rs_pkg::TARGET_RATE_RST;
         decoded_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) target_rate <= csr_target_rate;
         if (start && !busy) begin
            scaled = {11'd0, req_raw_range} * {16'd0, tof_rs_pkg::RANGE_SCALE}
                   + tof_rs_pkg::RANGE_ROUND;
            want.distance     = scaled[26:11];
            want.status_code  = status_of(req_raw_status, req_stream_cnt);
            want.spad_select  = spads_needed(req_effective_spads, req_signal_rate,
                                             req_ambient_rate, target_rate);
            want.signal_rate  = req_signal_rate;
            want.ambient_rate = req_ambient_rate;
            decoded_q.push_back(want);
         end
         if (rsp_valid) begin
            got = '{rsp_distance, rsp_status_code, rsp_spad_select,
                    rsp_signal_rate_out, rsp_ambient_rate_out};
            if (decoded_q.size() == 0) begin
               if (fail_count < 10) $display("ERROR: unexpected record %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = decoded_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("ERROR: range %0d/%0d status %0d/%0d spad %h/%h sig %h/%h amb %h/%h (exp/act)",
                              want.distance, got.distance, want.status_code, got.status_code,
                              want.spad_select, got.spad_select, want.signal_rate,
                              got.signal_rate, want.ambient_rate, got.ambient_rate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### verif/tof_result_status_and_spad_control_unit_tb.sv
// Testbench top for the time-of-flight result unit: drives records and
// target-rate writes, and gives the verdict from the checker's count.
// Depends on the RTL and the checker module.
module tof_result_status_and_spad_control_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 65;
   localparam int CYCLE_MAX = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_raw_status = '0;
   logic [7:0]  req_stream_cnt = '0;
   logic [15:0] req_effective_spads = '0;
   logic [15:0] req_ambient_rate = '0;
   logic [15:0] req_signal_rate = '0;
   logic [15:0] req_raw_range = '0;
   logic        rsp_valid;
   logic [15:0] rsp_distance;
   logic [3:0]  rsp_status_code;
   logic [15:0] rsp_spad_select;
   logic [15:0] rsp_signal_rate_out;
   logic [15:0] rsp_ambient_rate_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_target_rate = '0;
   int          fail_count;
   int          pending;
   int          cycles = 0;

   always #10 clock = ~clock;

   tof_result_status_and_spad_control_unit i_dut (.*);
   tof_result_status_and_spad_control_unit_checker i_checker (.*);

   // Abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one record and hold start until the transfer; drop start only
   // when an idle gap follows, so back-to-back records keep it high.
   task automatic send_record(logic [7:0] raw, logic [7:0] stream, logic [15:0] spads,
                              logic [15:0] amb, logic [15:0] sig, logic [15:0] range);
      int gap;
      start               <= 1'b1;
      req_raw_status      <= raw;
      req_stream_cnt      <= stream;
      req_effective_spads <= spads;
      req_ambient_rate    <= amb;
      req_signal_rate     <= sig;
      req_raw_range       <= range;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
          : ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain the pipeline before a register write, then transfer it.
   task automatic write_target(logic [15:0] value);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_target_rate <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random record, mostly with known status bytes and small SPAD counts so
   // the divider sees a wide spread of quotients.
   task automatic random_record();
      logic [7:0]  raw;
      logic [15:0] spads;
      logic [15:0] amb;
      logic [15:0] sig;
      raw   = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 19))
                                          : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0: spads = 16'($urandom_range(0, 3));
         1: spads = 16'($urandom);
         default: spads = 16'($urandom_range(256, 8191));
      endcase
      amb = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047));
      sig = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
      if ($urandom_range(0, 15) == 0) begin
         amb = 16'd0;
         sig = 16'($urandom_range(0, 1));
      end
      send_record(raw, ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom), spads,
                  amb, sig, 16'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every status byte up to 19 plus the top one, with the
      // range-valid byte seen with both zero and nonzero stream count.
      for (int r = 0; r < 20; r++)
         send_record(8'(r), 8'd5, 16'h0A00, 16'h0100, 16'h0400, 16'(r * 3300));
      send_record(8'd9, 8'd0, 16'h0A00, 16'h0100, 16'h0400, 16'd1);
      send_record(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // Zero SPAD count, zero per-SPAD rate, one SPAD with the smallest nonzero rate.
      send_record(8'd9, 8'd1, 16'h0000, 16'h1234, 16'h4321, 16'h0000);
      send_record(8'd9, 8'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
      send_record(8'd9, 8'd1, 16'h0001, 16'h0000, 16'h0001, 16'h8000);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: write_target(16'h0000);
            2: write_target(16'hFFFF);
            3: write_target(16'h0001);
            4: write_target(16'($urandom));
            default: ;
         endcase
         for (int n = 0; n < 80; n++) random_record();
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
